>>> rtl/sapi_pkg.sv
// shared constants, breakpoint table and stage types for the servo interpolator
package sapi_pkg;

  localparam int TABLE_POINTS = 38;
  localparam int SEG_W = $clog2(TABLE_POINTS);
  localparam int X_W = 11;     // clamped angle, signed, |x| <= 1023
  localparam int DX_W = 7;     // offset into a segment
  localparam int NUM_W = 14;   // dv * dx
  localparam int RCP_W = 22;   // reciprocal of a segment width
  localparam int RCP_SH = 24;
  localparam int CMP_W = 16;

  typedef logic signed [X_W-1:0] ang_t;
  typedef logic [CMP_W-1:0] cmp_t;

  localparam ang_t BP_ANG [TABLE_POINTS] = '{
    -11'sd560, -11'sd512, -11'sd464, -11'sd416, -11'sd384, -11'sd352, -11'sd320,
    -11'sd288, -11'sd224, -11'sd208, -11'sd160, -11'sd112, -11'sd96, -11'sd64,
    -11'sd32, -11'sd16, 11'sd0, 11'sd16, 11'sd24, 11'sd48, 11'sd72, 11'sd112,
    11'sd136, 11'sd160, 11'sd192, 11'sd208, 11'sd224, 11'sd240, 11'sd256,
    11'sd272, 11'sd320, 11'sd336, 11'sd352, 11'sd368, 11'sd384, 11'sd400,
    11'sd408, 11'sd416
  };

  localparam cmp_t BP_CMP [TABLE_POINTS] = '{
    16'd3200, 16'd3300, 16'd3400, 16'd3500, 16'd3600, 16'd3750, 16'd3800,
    16'd3900, 16'd4000, 16'd4100, 16'd4200, 16'd4300, 16'd4400, 16'd4500,
    16'd4600, 16'd4700, 16'd4800, 16'd4900, 16'd5000, 16'd5100, 16'd5200,
    16'd5300, 16'd5400, 16'd5500, 16'd5600, 16'd5700, 16'd5800, 16'd5900,
    16'd6000, 16'd6100, 16'd6200, 16'd6300, 16'd6400, 16'd6500, 16'd6600,
    16'd6700, 16'd6800, 16'd6900
  };

  // ceil(2^24 / width) for the segment widths present in the table
  function automatic logic [RCP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
    logic [X_W-1:0] d;
    logic [RCP_W-1:0] r;
    d = BP_ANG[seg+1'b1] - BP_ANG[seg];
    case (d)
      11'd8:   r = 22'd2097152;
      11'd16:  r = 22'd1048576;
      11'd24:  r = 22'd699051;
      11'd32:  r = 22'd524288;
      11'd40:  r = 22'd419431;
      11'd48:  r = 22'd349526;
      11'd64:  r = 22'd262144;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic              action;
    cmp_t              raw;
    logic              clamped;
    logic              sel_last;
    logic [SEG_W-1:0]  seg;
    logic [DX_W-1:0]   dx;
  } seg_t;

endpackage

>>> rtl/servo_angle_to_pwm_interpolator.sv
// top level of the servo angle to pwm compare interpolator
//
// input channel: in_tuser is the action bit (1 = pass in_tdata raw value
// through, 0 = interpolate the angle); in_tdata carries angle and raw value.
// result channel: out_tdata is the compare value, out_tuser flags an angle
// that was clamped by the limit or ran off the breakpoint table.
// cfg_wr_en / cfg_wr_data write the 10-bit symmetric angle limit (reset 560);
// the user writes it only while the block is idle; the block does not enforce this.
// five register stages: clamp, segment search, dv*dx multiply, reciprocal
// scale, output register. one transfer per cycle is accepted while the
// output is not stalled.
// when the receiver stalls the whole pipeline holds, so in_tready falls
// only while a result waits at the output; nothing is dropped or repeated.
// reset clears all valid bits and reloads the limit; no clearing pass.
module servo_angle_to_pwm_interpolator
  import sapi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // angle[11:0], raw_value[27:12], zero pad
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // compare_value[15:0]
  output logic        out_tuser,  // was_clamped
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data
);

  logic [9:0] limit_r;
  logic [4:0] vld_r, vld_nxt;
  logic       adv;
  seg_t       seg;

  // whole pipe moves unless a result sits at the output unaccepted
  assign adv = ~vld_r[4] | out_tready;
  assign in_tready = adv;
  assign vld_nxt = {vld_r[3:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 10'd560;
      vld_r <= '0;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (adv) vld_r <= vld_nxt;
    end
  end

  sapi_front u_front (
    .clk       (clk),
    .adv       (adv),
    .limit     (limit_r),
    .action    (in_tuser),
    .angle     (in_tdata[11:0]),
    .raw_value (in_tdata[27:12]),
    .seg_out   (seg)
  );

  sapi_interp u_interp (
    .clk           (clk),
    .adv           (adv),
    .seg_in        (seg),
    .compare_value (out_tdata),
    .was_clamped   (out_tuser)
  );

  assign out_tvalid = vld_r[4];

endmodule

>>> rtl/sapi_front.sv
// clamp stage and breakpoint segment search stage
module sapi_front
  import sapi_pkg::*;
(
  input  logic        clk,
  input  logic        adv,
  input  logic [9:0]  limit,
  input  logic        action,
  input  logic [11:0] angle,
  input  cmp_t        raw_value,
  output seg_t        seg_out
);

  logic        act1_r, clmp1_r;
  cmp_t        raw1_r;
  ang_t        x1_r;
  logic signed [12:0] a13, lim13;
  ang_t        x_nxt;
  logic        clmp_nxt;
  seg_t        seg_r, seg_nxt;
  logic [SEG_W-1:0] idx;
  ang_t        off;

  always_comb begin
    a13 = {angle[11], angle};
    lim13 = {3'b000, limit};
    x_nxt = a13[X_W-1:0];
    clmp_nxt = 1'b0;
    if (a13 < -lim13) begin
      x_nxt = -lim13[X_W-1:0];
      clmp_nxt = 1'b1;
    end else if (a13 > lim13) begin
      x_nxt = lim13[X_W-1:0];
      clmp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act1_r <= action;
      raw1_r <= raw_value;
      x1_r <= x_nxt;
      clmp1_r <= clmp_nxt;
    end
  end

  // last breakpoint at or below x among the interior segments
  always_comb begin
    idx = '0;
    for (int i = 1; i < TABLE_POINTS - 1; i++) begin
      if (BP_ANG[i] <= x1_r) idx = SEG_W'(i);
    end
    off = x1_r - BP_ANG[idx];
    seg_nxt.action = act1_r;
    seg_nxt.raw = raw1_r;
    seg_nxt.seg = idx;
    seg_nxt.dx = off[DX_W-1:0];
    seg_nxt.sel_last = 1'b0;
    seg_nxt.clamped = clmp1_r;
    if (x1_r <= BP_ANG[0]) begin
      seg_nxt.seg = '0;
      seg_nxt.dx = '0;
      if (x1_r < BP_ANG[0]) seg_nxt.clamped = 1'b1;
    end else if (x1_r >= BP_ANG[TABLE_POINTS-1]) begin
      seg_nxt.sel_last = 1'b1;
      seg_nxt.dx = '0;
      if (x1_r > BP_ANG[TABLE_POINTS-1]) seg_nxt.clamped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) seg_r <= seg_nxt;
  end

  assign seg_out = seg_r;

endmodule

>>> rtl/sapi_interp.sv
// multiply, reciprocal scale and output stages of the interpolation
module sapi_interp
  import sapi_pkg::*;
(
  input  logic clk,
  input  logic adv,
  input  seg_t seg_in,
  output cmp_t compare_value,
  output logic was_clamped
);

  seg_t             s3_r, s4_r;
  logic [NUM_W-1:0] num_r;
  logic [RCP_W-1:0] rcp_r;
  logic [NUM_W+RCP_W-1:0] prod_r;
  cmp_t             dv, v0, res_nxt;
  cmp_t             res_r;
  logic             clmp_r;
  logic [NUM_W+RCP_W-1:0] prod_sh;

  always_comb begin
    dv = BP_CMP[seg_in.seg+1'b1] - BP_CMP[seg_in.seg];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= seg_in;
      num_r <= NUM_W'(dv[7:0] * seg_in.dx);
      rcp_r <= seg_recip(seg_in.seg);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r <= s3_r;
      prod_r <= num_r * rcp_r;
    end
  end

  always_comb begin
    prod_sh = prod_r >> RCP_SH;
    v0 = BP_CMP[s4_r.seg];
    if (s4_r.action) res_nxt = s4_r.raw;
    else if (s4_r.sel_last) res_nxt = BP_CMP[TABLE_POINTS-1];
    else res_nxt = v0 + prod_sh[CMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      clmp_r <= s4_r.clamped & ~s4_r.action;
    end
  end

  assign compare_value = res_r;
  assign was_clamped = clmp_r;

endmodule

>>> rtl/sapi_checker.sv
// port-level checks for the servo interpolator, bound to the top level
module sapi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped during stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed during stall");

  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata >= 16'd3200 && out_tdata <= 16'd6900)
    else $error("clamped result outside table values");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind servo_angle_to_pwm_interpolator sapi_checker u_sapi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
